/* src/smbs_pkg.sv */
// Shared constants, codes and types for the sorted matrix binary search unit.
package smbs_pkg;

   localparam int MAX_ROWS_DEFAULT    = 64;
   localparam int MAX_COLS_DEFAULT    = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int INDEX_WIDTH     = 6;
   localparam int COUNT_WIDTH     = 7;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 7'd64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW_PROBE,
      S_ROW_FIRST,
      S_ROW_LAST,
      S_COL_PROBE,
      S_COL_CHECK
   } state_type;

endpackage

/* src/sorted_matrix_binary_search_unit.sv */
// Top level: count registers, count clamping, matrix RAM and search sequencer.
// A load transaction gives no response; one search is in flight at a time, at 64x64 with
// up to 7 row and 7 column probes. Each row probe walks S_ROW_PROBE, S_ROW_FIRST and
// S_ROW_LAST (two RAM reads, one compare), each column probe S_COL_PROBE and S_COL_CHECK;
// a miss ends on an empty range, and idle precedes the next accept; response stalls hold it.
// Synchronous reset sets both counts to 64 and idles the sequencer; matrix contents are kept.
module sorted_matrix_binary_search_unit import smbs_pkg::*; #(
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS    = MAX_COLS_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COUNT_WIDTH-1:0]        csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [INDEX_WIDTH-1:0]        req_row_index,
   input  logic [INDEX_WIDTH-1:0]        req_col_index,
   input  logic signed [VALUE_WIDTH-1:0] req_entry_value,
   input  logic signed [VALUE_WIDTH-1:0] req_target,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found
);

   localparam int NRW   = $clog2(MAX_ROWS + 1);
   localparam int NCW   = $clog2(MAX_COLS + 1);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [COUNT_WIDTH-1:0] row_count_ff, row_count_in;
   logic [COUNT_WIDTH-1:0] col_count_ff, col_count_in;
   logic [NRW-1:0]         rows;
   logic [NCW-1:0]         cols;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic                   mem_re;
   logic [AW-1:0]          mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_rdata;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= COUNT_RESET;
         col_count_ff <= COUNT_RESET;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   always_comb begin
      if (row_count_ff == '0) begin
         rows = NRW'(1);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         rows = NRW'(MAX_ROWS);
      end else begin
         rows = NRW'(row_count_ff);
      end
      if (col_count_ff == '0) begin
         cols = NCW'(1);
      end else if (32'(col_count_ff) > MAX_COLS) begin
         cols = NCW'(MAX_COLS);
      end else begin
         cols = NCW'(col_count_ff);
      end
   end

   smbs_search #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_search (
      .clock           (clock),
      .reset           (reset),
      .rows            (rows),
      .cols            (cols),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_entry_value (req_entry_value),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_re          (mem_re),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata)
   );

   smbs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_matrix_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

/* src/smbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module smbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/smbs_search.sv */
// Search sequencer: load writes, row and column binary searches, result register.
module smbs_search import smbs_pkg::*; #(
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS    = MAX_COLS_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int NRW = $clog2(MAX_ROWS + 1),
   localparam int NCW = $clog2(MAX_COLS + 1),
   localparam int NW  = (NRW > NCW) ? NRW : NCW,
   localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [NRW-1:0]                rows,
   input  logic [NCW-1:0]                cols,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [INDEX_WIDTH-1:0]        req_row_index,
   input  logic [INDEX_WIDTH-1:0]        req_col_index,
   input  logic signed [VALUE_WIDTH-1:0] req_entry_value,
   input  logic signed [VALUE_WIDTH-1:0] req_target,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic                          mem_we,
   output logic [AW-1:0]                 mem_waddr,
   output logic [VALUE_WIDTH-1:0]        mem_wdata,
   output logic                          mem_re,
   output logic [AW-1:0]                 mem_raddr,
   input  logic [VALUE_WIDTH-1:0]        mem_rdata
);

   state_type                   state_ff, state_in;
   logic [NW-1:0]               lo_ff, lo_in;
   logic [NW-1:0]               hip_ff, hip_in;
   logic [NW-1:0]               mid_ff, mid_in;
   logic [RW-1:0]               row_ff, row_in;
   logic signed [VALUE_WIDTH-1:0] first_ff, first_in;
   logic signed [VALUE_WIDTH-1:0] target_ff, target_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;

   logic                        out_free;
   logic                        load_in_range;
   logic [NW-1:0]               probe_mid;
   logic signed [VALUE_WIDTH-1:0] rd_value;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
      return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
   endfunction

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign load_in_range = (32'(req_row_index) < MAX_ROWS) && (32'(req_col_index) < MAX_COLS);
   assign probe_mid     = NW'(((NW+1)'(lo_ff) + (NW+1)'(hip_ff) - (NW+1)'(1)) >> 1);
   assign rd_value      = $signed(mem_rdata);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   assign mem_waddr = cell_addr(RW'(req_row_index), CW'(req_col_index));
   assign mem_wdata = req_entry_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hip_ff       <= hip_in;
      mid_ff       <= mid_in;
      row_ff       <= row_in;
      first_ff     <= first_in;
      target_ff    <= target_in;
      rsp_found_ff <= rsp_found_in;
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hip_in       = hip_ff;
      mid_in       = mid_ff;
      row_in       = row_ff;
      first_in     = first_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  mem_we = load_in_range;
               end else begin
                  target_in = req_target;
                  lo_in     = '0;
                  hip_in    = NW'(rows);
                  state_in  = S_ROW_PROBE;
               end
            end
         end
         S_ROW_PROBE: begin
            if (lo_ff >= hip_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end else begin
               mid_in    = probe_mid;
               mem_re    = 1'b1;
               mem_raddr = cell_addr(RW'(probe_mid), '0);
               state_in  = S_ROW_FIRST;
            end
         end
         S_ROW_FIRST: begin
            first_in  = rd_value;
            mem_re    = 1'b1;
            mem_raddr = cell_addr(RW'(mid_ff), CW'(cols - NCW'(1)));
            state_in  = S_ROW_LAST;
         end
         S_ROW_LAST: begin
            if (target_ff >= first_ff && target_ff <= rd_value) begin
               row_in   = RW'(mid_ff);
               lo_in    = '0;
               hip_in   = NW'(cols);
               state_in = S_COL_PROBE;
            end else begin
               if (target_ff <= first_ff) begin
                  hip_in = mid_ff;
               end else begin
                  lo_in = mid_ff + NW'(1);
               end
               state_in = S_ROW_PROBE;
            end
         end
         S_COL_PROBE: begin
            if (lo_ff >= hip_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end else begin
               mid_in    = probe_mid;
               mem_re    = 1'b1;
               mem_raddr = cell_addr(row_ff, CW'(probe_mid));
               state_in  = S_COL_CHECK;
            end
         end
         S_COL_CHECK: begin
            if (target_ff == rd_value) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               if (target_ff > rd_value) begin
                  lo_in = mid_ff + NW'(1);
               end else begin
                  hip_in = mid_ff;
               end
               state_in = S_COL_PROBE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* src/smbs_checker.sv */
// Port-level assertions for the sorted matrix binary search unit, bound to the top level.
module smbs_checker import smbs_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_mode,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_found
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found))
      else $error("response dropped or changed while stalled");

   // a load transaction never creates a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load transaction produced a response");

   // a search transaction makes the unit busy
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_SEARCH |=> req_stall)
      else $error("search accepted without going busy");

   // a new response only comes out of a search in progress
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared while idle");

endmodule

bind sorted_matrix_binary_search_unit smbs_checker u_smbs_checker (.*);
